/* sv/etw_pkg.sv */
// shared types and constants of the eased tween engine
`default_nettype none

package etw_pkg;

  // register indexes of the configuration port
  localparam logic [7:0] REG_START_VALUE = 8'd0;
  localparam logic [7:0] REG_END_VALUE   = 8'd1;
  localparam logic [7:0] REG_START_COLOR = 8'd2;
  localparam logic [7:0] REG_END_COLOR   = 8'd3;
  localparam logic [7:0] REG_DURATION    = 8'd4;
  localparam logic [7:0] REG_EASING      = 8'd5;
  localparam logic [7:0] REG_KIND        = 8'd6;
  localparam logic [7:0] REG_OPTIONS     = 8'd7;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 32;

  // input opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // easing curves
  localparam logic [1:0] CURVE_LINEAR = 2'd0;
  localparam logic [1:0] CURVE_IN     = 2'd1;
  localparam logic [1:0] CURVE_OUT    = 2'd2;
  localparam logic [1:0] CURVE_INOUT  = 2'd3;

  // value kinds
  localparam logic [1:0] KIND_FRAC  = 2'd0;
  localparam logic [1:0] KIND_INT   = 2'd1;
  localparam logic [1:0] KIND_COLOR = 2'd2;

  // option bits
  localparam int unsigned OPT_REPEAT = 0;
  localparam int unsigned OPT_OFF    = 1;

  // integer rounding works on the Q16.16 scalar
  localparam int unsigned QFRAC = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_ESET,
    ST_EASE,
    ST_ECLP,
    ST_BSET,
    ST_BLEND
  } state_e;

endpackage

`default_nettype wire

/* sv/etw_intf.sv */
// valid/ready channel interfaces of the eased tween engine
`default_nettype none

interface etw_in_if #(parameter int unsigned TIME_BITS = 48);
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [TIME_BITS-1:0] now_ms;
  modport source (output valid, opcode, now_ms, input ready);
  modport sink   (input valid, opcode, now_ms, output ready);
endinterface

interface etw_out_if;
  logic        valid;
  logic        ready;
  logic        ran;
  logic [31:0] value_out;
  logic [31:0] color_out;
  logic        finished;
  logic        element_off;
  logic        still_active;
  modport source (output valid, ran, value_out, color_out, finished, element_off,
                  still_active, input ready);
  modport sink   (input valid, ran, value_out, color_out, finished, element_off,
                  still_active, output ready);
endinterface

interface etw_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/eased_tween_engine.sv */
// eased tween engine: serial divider, shift-add easing and blending multipliers
// a start only arms the tween; an idle tick goes out as all zero; a tick in a period
// runs the serial divider (not before the anchor), the shift-add easing (not for
// linear) and the blend pass; the end of a period skips divider and easing;
// one item is taken at a time; a finished result may wait in the output register
// reset: tween disarmed, endpoints and anchor zero, registers at their defaults
`default_nettype none

module eased_tween_engine #(
  parameter int unsigned TIME_BITS = 48,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire           clk_i,
  input  wire           rst_ni,
  etw_in_if.sink        in_i,
  etw_out_if.source     out_o,
  etw_cfg_if.sink       cfg_i
);
  import etw_pkg::*;

  // widths of the fixed point datapath
  localparam int unsigned TW   = FRAC_BITS + 1;       // progress / eased value
  localparam int unsigned MW   = FRAC_BITS + 3;       // ease multiplicand, up to 3.0
  localparam int unsigned EPW  = MW + TW;             // ease product
  localparam int unsigned PW   = 33 + TW;             // scalar blend product
  localparam int unsigned CW   = 9 + TW;              // colour channel product
  localparam int unsigned CNTW = $clog2(TW + 1);

  localparam logic [TW-1:0] ONE_T  = TW'(1) << FRAC_BITS;
  localparam logic [TW-1:0] HALF_T = ONE_T >> 1;

  // configuration registers
  logic [31:0] start_value_q, end_value_q, start_color_q, end_color_q, duration_q;
  logic [1:0]  easing_q, kind_q, options_q;

  // tween state
  logic                 running_q, running_d;
  logic [TIME_BITS-1:0] anchor_q, anchor_d;
  logic [31:0]          from_q, from_d, to_q, to_d;
  logic [31:0]          fromc_q, fromc_d, toc_q, toc_d;

  // sequencer and datapath
  state_e               state_q, state_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [CNTW-1:0]      cnt_q, cnt_d;
  logic [32:0]          rem_q, rem_d;
  logic [TW-1:0]        t_q, t_d;
  logic [TW-1:0]        e_q, e_d;
  logic [TW-1:0]        msh_q, msh_d;        // multiplier bits, shifted out lsb first
  logic [EPW-1:0]       ea_q, ea_d;          // ease addend, shifted left
  logic [EPW-1:0]       eacc_q, eacc_d;
  logic signed [PW-1:0] sa_q, sa_d, sacc_q, sacc_d;
  logic signed [CW-1:0] ca_q [4];
  logic signed [CW-1:0] ca_d [4];
  logic signed [CW-1:0] cacc_q [4];
  logic signed [CW-1:0] cacc_d [4];

  // result flags of the tick under work
  logic ran_q, ran_d, fin_q, fin_d, off_q, off_d, still_q, still_d;

  // output register
  logic        ovalid_q, ovalid_d;
  logic        oran_q, ofin_q, ooff_q, ostill_q;
  logic [31:0] ovalue_q, ocolor_q;
  logic        load_out;

  // combinational helpers
  logic                 in_fire, cfg_fire;
  logic [TIME_BITS-1:0] elapsed;
  logic                 dur_zero, early, full;
  logic [32:0]          rem2;
  logic [MW-1:0]        mcand;
  logic [EPW-1:0]       eprod;
  logic [32:0]          sdiff;
  logic signed [PW-1:0] prod_adj, prod_q;
  logic signed [33:0]   vsum, vint, vint_adj, vint_sh;
  logic [31:0]          value_res, color_res;
  logic signed [CW-1:0] cp [4];
  logic [8:0]           cdiff [4];

  assign in_fire   = in_i.valid && in_i.ready;
  assign cfg_fire  = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == ST_IDLE);

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_value_q <= '0;
      end_value_q   <= 32'd65536;
      start_color_q <= '0;
      end_color_q   <= '0;
      duration_q    <= '0;
      easing_q      <= CURVE_INOUT;
      kind_q        <= KIND_FRAC;
      options_q     <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_i.index)
        REG_START_VALUE: start_value_q <= cfg_i.data;
        REG_END_VALUE:   end_value_q   <= cfg_i.data;
        REG_START_COLOR: start_color_q <= cfg_i.data;
        REG_END_COLOR:   end_color_q   <= cfg_i.data;
        REG_DURATION:    duration_q    <= cfg_i.data;
        REG_EASING:      easing_q      <= cfg_i.data[1:0];
        REG_KIND:        kind_q        <= cfg_i.data[1:0];
        REG_OPTIONS:     options_q     <= cfg_i.data[1:0];
        default: ;
      endcase
    end
  end

  // progress tests on the latched time
  assign elapsed  = now_q - anchor_q;
  assign dur_zero = (duration_q == '0);
  assign early    = (now_q <= anchor_q);
  assign full     = dur_zero || (!early && (elapsed >= TIME_BITS'(duration_q)));

  // one restoring divider step
  assign rem2 = {rem_q[31:0], 1'b0};

  // multiplicand of the easing product for the current curve
  always_comb begin
    case (easing_q)
      CURVE_OUT:   mcand = (MW'(ONE_T) << 1) - MW'(t_q);
      CURVE_INOUT: mcand = (t_q < HALF_T) ? (MW'(t_q) << 1)
                                          : ((MW'(ONE_T) << 2) - (MW'(t_q) << 1));
      default:     mcand = MW'(t_q);
    endcase
  end

  // scale the easing product back, less one for the upper half of in-out
  always_comb begin
    eprod = eacc_q >> FRAC_BITS;
    if (easing_q == CURVE_INOUT && t_q >= HALF_T) begin
      eprod = eprod - EPW'(ONE_T);
    end
  end

  assign sdiff = {to_q[31], to_q} - {from_q[31], from_q};

  // final rounding of the scalar and colour products
  always_comb begin
    prod_adj = sacc_q;
    if (sacc_q < 0) begin
      prod_adj = sacc_q + $signed(PW'(ONE_T - TW'(1)));
    end
    prod_q   = prod_adj >>> FRAC_BITS;
    vsum     = $signed({{2{from_q[31]}}, from_q}) + $signed(prod_q[33:0]);
    vint     = vsum + 34'sd32768;
    vint_adj = (vint < 0) ? (vint + 34'sd65535) : vint;
    vint_sh  = vint_adj >>> QFRAC;
    case (kind_q)
      KIND_INT:   value_res = vint_sh[31:0];
      KIND_COLOR: value_res = '0;
      default:    value_res = vsum[31:0];
    endcase
    for (int i = 0; i < 4; i++) begin
      cp[i] = (cacc_q[i] + $signed(CW'(HALF_T))) >>> FRAC_BITS;
      cdiff[i] = {1'b0, toc_q[8*i +: 8]} - {1'b0, fromc_q[8*i +: 8]};
    end
    color_res = '0;
    if (kind_q == KIND_COLOR) begin
      for (int i = 0; i < 4; i++) begin
        color_res[8*i +: 8] = fromc_q[8*i +: 8] + cp[i][7:0];
      end
    end
  end

  // state register and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      running_q <= 1'b0;
      anchor_q  <= '0;
      from_q    <= '0;
      to_q      <= '0;
      fromc_q   <= '0;
      toc_q     <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      anchor_q  <= anchor_d;
      from_q    <= from_d;
      to_q      <= to_d;
      fromc_q   <= fromc_d;
      toc_q     <= toc_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    cnt_q   <= cnt_d;
    rem_q   <= rem_d;
    t_q     <= t_d;
    e_q     <= e_d;
    msh_q   <= msh_d;
    ea_q    <= ea_d;
    eacc_q  <= eacc_d;
    sa_q    <= sa_d;
    sacc_q  <= sacc_d;
    ran_q   <= ran_d;
    fin_q   <= fin_d;
    off_q   <= off_d;
    still_q <= still_d;
    for (int i = 0; i < 4; i++) begin
      ca_q[i]   <= ca_d[i];
      cacc_q[i] <= cacc_d[i];
    end
    if (load_out) begin
      oran_q   <= ran_q;
      ofin_q   <= fin_q;
      ooff_q   <= off_q;
      ostill_q <= still_q;
      ovalue_q <= ran_q ? value_res : '0;
      ocolor_q <= ran_q ? color_res : '0;
    end
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_d   = state_q;
    running_d = running_q;
    anchor_d  = anchor_q;
    from_d    = from_q;
    to_d      = to_q;
    fromc_d   = fromc_q;
    toc_d     = toc_q;
    now_d     = now_q;
    cnt_d     = cnt_q;
    rem_d     = rem_q;
    t_d       = t_q;
    e_d       = e_q;
    msh_d     = msh_q;
    ea_d      = ea_q;
    eacc_d    = eacc_q;
    sa_d      = sa_q;
    sacc_d    = sacc_q;
    ran_d     = ran_q;
    fin_d     = fin_q;
    off_d     = off_q;
    still_d   = still_q;
    for (int i = 0; i < 4; i++) begin
      ca_d[i]   = ca_q[i];
      cacc_d[i] = cacc_q[i];
    end
    load_out = 1'b0;
    ovalid_d = ovalid_q && !out_o.ready;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.opcode == OP_START) begin
            // arm: copy endpoints and anchor the time
            from_d    = start_value_q;
            to_d      = end_value_q;
            fromc_d   = start_color_q;
            toc_d     = end_color_q;
            anchor_d  = in_i.now_ms;
            running_d = 1'b1;
          end else begin
            now_d   = in_i.now_ms;
            ran_d   = running_q;
            fin_d   = 1'b0;
            off_d   = 1'b0;
            still_d = 1'b0;
            // an idle tick goes straight out as all zero
            state_d = running_q ? ST_PREP : ST_BLEND;
            cnt_d   = '0;
          end
        end
      end
      ST_PREP: begin
        if (full) begin
          if (options_q[OPT_REPEAT] && !dur_zero) begin
            // ping-pong: swap ends, advance one period, emit from the new start
            from_d   = to_q;
            to_d     = from_q;
            fromc_d  = toc_q;
            toc_d    = fromc_q;
            anchor_d = anchor_q + TIME_BITS'(duration_q);
            e_d      = '0;
            still_d  = 1'b1;
          end else begin
            e_d       = ONE_T;
            running_d = 1'b0;
            fin_d     = 1'b1;
            off_d     = options_q[OPT_OFF];
          end
          state_d = ST_BSET;
        end else begin
          still_d = 1'b1;
          t_d     = '0;
          if (early) begin
            state_d = ST_ESET;
          end else begin
            rem_d   = {1'b0, elapsed[31:0]};
            cnt_d   = CNTW'(FRAC_BITS);
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (rem2 >= {1'b0, duration_q}) begin
          rem_d = rem2 - {1'b0, duration_q};
          t_d   = {t_q[TW-2:0], 1'b1};
        end else begin
          rem_d = rem2;
          t_d   = {t_q[TW-2:0], 1'b0};
        end
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          state_d = ST_ESET;
        end
      end
      ST_ESET: begin
        if (easing_q == CURVE_LINEAR) begin
          e_d     = t_q;
          state_d = ST_BSET;
        end else begin
          ea_d    = EPW'(mcand);
          msh_d   = t_q;
          eacc_d  = '0;
          cnt_d   = CNTW'(TW);
          state_d = ST_EASE;
        end
      end
      ST_EASE: begin
        if (msh_q[0]) begin
          eacc_d = eacc_q + ea_q;
        end
        ea_d  = ea_q << 1;
        msh_d = msh_q >> 1;
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          state_d = ST_ECLP;
        end
      end
      ST_ECLP: begin
        e_d     = (eprod > EPW'(ONE_T)) ? ONE_T : eprod[TW-1:0];
        state_d = ST_BSET;
      end
      ST_BSET: begin
        sa_d   = $signed({{(PW-33){sdiff[32]}}, sdiff});
        sacc_d = '0;
        for (int i = 0; i < 4; i++) begin
          ca_d[i]   = $signed({{(CW-9){cdiff[i][8]}}, cdiff[i]});
          cacc_d[i] = '0;
        end
        msh_d   = e_q;
        cnt_d   = CNTW'(TW);
        state_d = ST_BLEND;
      end
      ST_BLEND: begin
        if (cnt_q != '0) begin
          // scalar and four colour lanes share the serial pass over e
          if (msh_q[0]) begin
            sacc_d = sacc_q + sa_q;
            for (int i = 0; i < 4; i++) begin
              cacc_d[i] = cacc_q[i] + ca_q[i];
            end
          end
          sa_d = sa_q <<< 1;
          for (int i = 0; i < 4; i++) begin
            ca_d[i] = ca_q[i] <<< 1;
          end
          msh_d = msh_q >> 1;
          cnt_d = cnt_q - CNTW'(1);
        end else if (!ovalid_q || out_o.ready) begin
          load_out = 1'b1;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_o.valid        = ovalid_q;
  assign out_o.ran          = oran_q;
  assign out_o.value_out    = ovalue_q;
  assign out_o.color_out    = ocolor_q;
  assign out_o.finished     = ofin_q;
  assign out_o.element_off  = ooff_q;
  assign out_o.still_active = ostill_q;

`ifndef NO_ASSERTIONS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_i.ready)
    else $error("input taken while a tick is in work");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < {1'b0, duration_q}))
    else $error("divider remainder out of range");

  a_ease_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BSET) |-> (e_q <= ONE_T))
    else $error("eased value above one");

  a_fin_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.finished && out_o.still_active) &&
                    (out_o.ran || (!out_o.finished && !out_o.still_active)))
    else $error("inconsistent result flags");

  a_fin_disarms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && fin_q |=> !running_q)
    else $error("finished tween still armed");
`endif

endmodule

`default_nettype wire

/* tb/tb_eased_tween_engine.sv */
// testbench of the eased tween engine: directed and random tween traffic with a scoreboard
`default_nettype none

module tb_eased_tween_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import etw_pkg::*;

  localparam int unsigned TB_TIME_BITS = 48;
  localparam int unsigned TB_FRAC_BITS = 16;
  localparam longint unsigned ONE_Q = 64'd1 << TB_FRAC_BITS;
  localparam longint unsigned HALF_Q = 64'd1 << (TB_FRAC_BITS - 1);
  localparam longint unsigned TIME_MASK = (64'd1 << TB_TIME_BITS) - 1;
  localparam longint unsigned CYCLE_LIMIT = 64'd3_000_000;
  localparam int unsigned ENGINE_LATENCY = 80;

  typedef struct packed {
    logic        ran;
    logic [31:0] value_out;
    logic [31:0] color_out;
    logic        finished;
    logic        element_off;
    logic        still_active;
  } tween_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  etw_in_if #(.TIME_BITS(TB_TIME_BITS)) in_if ();
  etw_out_if out_if ();
  etw_cfg_if cfg_if ();

  eased_tween_engine #(.TIME_BITS(TB_TIME_BITS), .FRAC_BITS(TB_FRAC_BITS)) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if.sink),
    .out_o (out_if.source),
    .cfg_i (cfg_if.sink)
  );

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow of the configuration registers
  logic [31:0] sh_start_value, sh_end_value, sh_start_color, sh_end_color, sh_duration;
  logic [1:0]  sh_easing, sh_kind, sh_options;
  // shadow of the tween state
  logic        sh_running;
  logic [47:0] sh_anchor;
  logic [31:0] sh_from, sh_to, sh_from_color, sh_to_color;

  tween_result_t tween_expected_q[$];
  int unsigned   fail_count = 0;
  int unsigned   sender_idle_pct = 0;   // chance per cycle that the sender holds back
  int unsigned   receiver_stall_pct = 0;
  int unsigned   hold_off_cycles = 0;   // long receiver hold-off, counted down below
  longint unsigned cycle_count = 0;
  longint unsigned clock_ms = 0;        // running time base for the random traffic

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned ease_progress(longint unsigned t, logic [1:0] mode);
    longint unsigned e;
    if (t > ONE_Q) t = ONE_Q;
    case (mode)
      CURVE_IN:  e = (t * t) >> TB_FRAC_BITS;
      CURVE_OUT: e = (t * (2 * ONE_Q - t)) >> TB_FRAC_BITS;
      CURVE_INOUT: begin
        if (t < HALF_Q) e = (2 * t * t) >> TB_FRAC_BITS;
        else e = (((4 * ONE_Q - 2 * t) * t) >> TB_FRAC_BITS) - ONE_Q;
      end
      default: e = t;
    endcase
    return (e > ONE_Q) ? ONE_Q : e;
  endfunction

  // rounded per-channel blend, floor of the scaled difference plus one half
  function automatic logic [31:0] mix_argb(logic [31:0] c0, logic [31:0] c1,
                                           longint unsigned e);
    logic [31:0] res;
    longint a, b, x, ch;
    res = '0;
    for (int sh = 0; sh < 32; sh += 8) begin
      a = longint'(c0[sh +: 8]);
      b = longint'(c1[sh +: 8]);
      x = (b - a) * longint'(e) + longint'(HALF_Q);
      ch = a + (x >>> TB_FRAC_BITS);
      res[sh +: 8] = ch[7:0];
    end
    return res;
  endfunction

  function automatic void fill_value(longint unsigned e, ref tween_result_t r);
    longint from, diff, v, q;
    from = longint'(signed'(sh_from));
    diff = longint'(signed'(sh_to)) - from;
    v = from + (diff * longint'(e)) / longint'(ONE_Q);
    r.value_out = '0;
    r.color_out = '0;
    if (sh_kind == KIND_COLOR) begin
      r.color_out = mix_argb(sh_from_color, sh_to_color, e);
    end else if (sh_kind == KIND_INT) begin
      q = (v + 32768) / 65536;
      r.value_out = q[31:0];
    end else begin
      r.value_out = v[31:0];
    end
  endfunction

  // advances the tween state for one item and queues the result of a tick
  function automatic void predict_tween(logic op, logic [47:0] now);
    tween_result_t r;
    longint unsigned t, el;
    logic [31:0] tmp;
    if (op == OP_START) begin
      sh_from = sh_start_value;
      sh_to = sh_end_value;
      sh_from_color = sh_start_color;
      sh_to_color = sh_end_color;
      sh_anchor = now;
      sh_running = 1'b1;
      return;
    end
    r = '0;
    if (!sh_running) begin
      tween_expected_q.push_back(r);
      return;
    end
    r.ran = 1'b1;
    if (sh_duration == 0) begin
      t = ONE_Q;
    end else if (now <= sh_anchor) begin
      t = 0;
    end else begin
      el = 64'(now) - 64'(sh_anchor);
      t = (el >= 64'(sh_duration)) ? ONE_Q : (el << TB_FRAC_BITS) / 64'(sh_duration);
    end
    if (t >= ONE_Q) begin
      if (sh_options[OPT_REPEAT] && sh_duration != 0) begin
        // ping-pong: swap endpoints and move the anchor one period on
        tmp = sh_from; sh_from = sh_to; sh_to = tmp;
        tmp = sh_from_color; sh_from_color = sh_to_color; sh_to_color = tmp;
        sh_anchor = 48'((64'(sh_anchor) + 64'(sh_duration)) & TIME_MASK);
        fill_value(0, r);
        r.still_active = 1'b1;
      end else begin
        fill_value(ONE_Q, r);
        sh_running = 1'b0;
        r.finished = 1'b1;
        r.element_off = sh_options[OPT_OFF];
      end
    end else begin
      fill_value(ease_progress(t, sh_easing), r);
      r.still_active = 1'b1;
    end
    tween_expected_q.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  initial begin
    in_if.valid = 1'b0;
    in_if.opcode = 1'b0;
    in_if.now_ms = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  // one tween transaction, with random idle cycles in front
  task automatic send_item(logic op, logic [47:0] now);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.now_ms <= now;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    predict_tween(op, now);
  endtask

  // register write, only issued while the engine is idle
  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= data;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    case (idx)
      REG_START_VALUE: sh_start_value = data;
      REG_END_VALUE:   sh_end_value = data;
      REG_START_COLOR: sh_start_color = data;
      REG_END_COLOR:   sh_end_color = data;
      REG_DURATION:    sh_duration = data;
      REG_EASING:      sh_easing = data[1:0];
      REG_KIND:        sh_kind = data[1:0];
      REG_OPTIONS:     sh_options = data[1:0];
      default: ;
    endcase
  endtask

  // wait for every expected result, then let a start transaction settle
  task automatic drain();
    in_if.valid <= 1'b0;
    while (tween_expected_q.size() != 0) @(posedge clk_i);
    repeat (ENGINE_LATENCY) @(posedge clk_i);
  endtask

  task automatic load_tween(logic [31:0] sv, logic [31:0] ev, logic [31:0] sc,
                            logic [31:0] ec, logic [31:0] dur, logic [1:0] ease,
                            logic [1:0] kind, logic [1:0] opt);
    drain();
    write_reg(REG_START_VALUE, sv);
    write_reg(REG_END_VALUE, ev);
    write_reg(REG_START_COLOR, sc);
    write_reg(REG_END_COLOR, ec);
    write_reg(REG_DURATION, dur);
    write_reg(REG_EASING, {30'd0, ease});
    write_reg(REG_KIND, {30'd0, kind});
    write_reg(REG_OPTIONS, {30'd0, opt});
    cfg_if.valid <= 1'b0;
  endtask

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    tween_result_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = '{out_if.ran, out_if.value_out, out_if.color_out, out_if.finished,
              out_if.element_off, out_if.still_active};
      if (tween_expected_q.size() == 0) begin
        $display("%0t: unexpected result transaction %h", $realtime, got);
        fail_count++;
      end else begin
        want = tween_expected_q.pop_front();
        if (got.ran !== want.ran) begin
          $display("%0t: ran expected %0b actual %0b", $realtime, want.ran, got.ran);
          fail_count++;
        end
        if (got.value_out !== want.value_out) begin
          $display("%0t: value_out expected %h actual %h", $realtime,
                   want.value_out, got.value_out);
          fail_count++;
        end
        if (got.color_out !== want.color_out) begin
          $display("%0t: color_out expected %h actual %h", $realtime,
                   want.color_out, got.color_out);
          fail_count++;
        end
        if (got.finished !== want.finished) begin
          $display("%0t: finished expected %0b actual %0b", $realtime,
                   want.finished, got.finished);
          fail_count++;
        end
        if (got.element_off !== want.element_off) begin
          $display("%0t: element_off expected %0b actual %0b", $realtime,
                   want.element_off, got.element_off);
          fail_count++;
        end
        if (got.still_active !== want.still_active) begin
          $display("%0t: still_active expected %0b actual %0b", $realtime,
                   want.still_active, got.still_active);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL eased_tween_engine");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // idle ticks before any start, at the extremes of the time field
  task automatic test_idle_ticks();
    send_item(OP_TICK, '0);
    send_item(OP_TICK, '1);
    send_item(OP_TICK, 48'h5555_5555_5555);
  endtask

  // every curve at quarter, half and three quarters, plus time before the anchor
  task automatic test_curves();
    for (int m = 0; m < 4; m++) begin
      load_tween(32'h8000_0000, 32'h7fff_ffff, 32'h00ff_00ff, 32'hff00_ff00, 32'd1000,
                 m[1:0], (m == 3) ? 2'd3 : m[1:0], 2'd0);
      send_item(OP_START, 48'd5000);
      send_item(OP_TICK, 48'd4000);
      send_item(OP_TICK, 48'd5250);
      send_item(OP_TICK, 48'd5500);
      send_item(OP_TICK, 48'd5750);
    end
  endtask

  // zero duration with repeat set still finishes, element switched off
  task automatic test_zero_duration();
    load_tween(32'd123, 32'hffff_0000, 32'hffff_ffff, 32'd0, 32'd0, CURVE_INOUT,
               KIND_INT, 2'd3);
    send_item(OP_START, 48'd10);
    send_item(OP_TICK, 48'd10);
    send_item(OP_TICK, 48'd11);
  endtask

  // ping-pong armed near the end of the time range, maximum duration; no period ends
  task automatic test_ping_pong();
    load_tween(32'd0, 32'd65536, 32'h1234_5678, 32'h89ab_cdef, 32'hffff_ffff, CURVE_OUT,
               KIND_COLOR, 2'd1);
    send_item(OP_START, 48'hffff_ffff_0000);
    send_item(OP_TICK, 48'hffff_ffff_ffff);
    send_item(OP_TICK, 48'hffff_ffff_fffe);
    send_item(OP_TICK, 48'hffff_ffff_fff0);
    drain();
    write_reg(8'd200, 32'hdead_beef);   // out of range index, ignored
    cfg_if.valid <= 1'b0;
  endtask

  task automatic random_traffic(int unsigned n_items, int unsigned idle_pct,
                                int unsigned stall_pct);
    logic [31:0] dur;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int unsigned sent = 0; sent < n_items;) begin
      dur = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(200));
      if ($urandom_range(15) == 0) dur = 0;
      load_tween($urandom, $urandom, $urandom, $urandom, dur, 2'($urandom),
                 2'($urandom_range(3)), 2'($urandom));
      if ($urandom_range(7) == 0) clock_ms = {$urandom, $urandom} & TIME_MASK;
      send_item(OP_START, 48'(clock_ms));
      sent++;
      for (int k = 0; k < 8 + $urandom_range(16); k++) begin
        if ($urandom_range(19) == 0) begin
          send_item(OP_TICK, 48'({$urandom, $urandom}));   // noise time
        end else begin
          clock_ms = (clock_ms + $urandom_range(60)) & TIME_MASK;
          send_item(($urandom_range(24) == 0) ? OP_START : OP_TICK, 48'(clock_ms));
        end
        sent++;
      end
    end
  endtask

  // the receiver holds off long enough for the engine to stall its input
  task automatic test_back_pressure();
    load_tween(32'd0, 32'd655360, 32'd0, 32'hffff_ffff, 32'd100, CURVE_LINEAR,
               KIND_FRAC, 2'd1);
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    send_item(OP_START, 48'd0);
    hold_off_cycles = 600;
    for (int k = 1; k <= 20; k++) send_item(OP_TICK, 48'(k * 17));
  endtask

  initial begin
    sh_start_value = 0; sh_end_value = 65536; sh_start_color = 0; sh_end_color = 0;
    sh_duration = 0; sh_easing = CURVE_INOUT; sh_kind = KIND_FRAC; sh_options = 0;
    sh_running = 0; sh_anchor = 0;
    sh_from = 0; sh_to = 0; sh_from_color = 0; sh_to_color = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_ticks();
    test_curves();
    test_zero_duration();
    test_ping_pong();
    test_back_pressure();
    random_traffic(450, 0, 0);
    random_traffic(430, 73, 0);
    random_traffic(430, 0, 73);
    random_traffic(430, 36, 36);

    drain();
    if (fail_count == 0) begin
      $display("PASS eased_tween_engine");
    end else begin
      $display("FAIL eased_tween_engine");
    end
    $finish;
  end

endmodule

`default_nettype wire
